[design/whtok_pkg.sv]
`default_nettype none

package whtok_pkg;

	// Payload of one text beat.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} tok_in_t;

	// Payload of one token beat.
	typedef struct packed {
		logic [31:0] token_id;
		logic        is_eos;
		logic        last_of_run;
	} tok_out_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EOS_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EOS_TOKEN    = 1'd1;

	localparam logic [15:0] EOS_INTERVAL_RST = 16'd64;
	localparam logic [31:0] EOS_TOKEN_RST    = 32'd0;

	// Characters that may close a sentence.
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_DOT = 8'h2E;

	// Start value (not the FNV-1a basis); prime 2^40 + 0x1B3, as shifts and adds.
	localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

	// Vocabulary size and the constants of the modulo pipeline.
	localparam logic [31:0] VOCAB_SIZE = 32'd248319;
	localparam int          VOC_W      = 18;
	localparam logic [63:0] VocabWide  = 64'(VOCAB_SIZE);
	localparam logic [VOC_W-1:0] RES24 = VOC_W'((64'd1 << 24) % VocabWide);
	localparam logic [VOC_W-1:0] RES32 = VOC_W'((64'd1 << 32) % VocabWide);
	localparam logic [VOC_W-1:0] RES48 = VOC_W'((64'd1 << 48) % VocabWide);
	localparam int          RECIP_SHIFT = 49;
	localparam logic [31:0] RECIP_K     = 32'((64'd1 << RECIP_SHIFT) / VocabWide);
	localparam int          QUOT_W      = 14;

	// Result queue.
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// One queued entry: up to a word token followed by an end-of-sentence token.
	typedef struct packed {
		logic        word_v;
		logic        eos_v;
		logic [31:0] word_id;
	} tok_job_t;

endpackage

`default_nettype wire

[design/word_hash_tokenizer.sv]
`default_nettype none

// Streaming word tokenizer with 64-bit FNV-1a-style word hashing.
// Text arrives one byte per beat on the text channel (valid/ready); bytes of
// letters, digits and underscore build a word, any other byte ends it. Each
// finished word leaves on the token channel as (hash mod 248319) + 1. A
// newline or full stop also emits the configured end-of-sentence token once
// at least eos_interval words have passed since the previous one. A beat
// flagged end_of_text flushes the pending word and restarts the word count.
// One text beat gives zero, one or two token beats; last_of_run marks the
// final one.
//
// Throughput is one text byte per cycle while text_ready is high: the hash
// update is a xor and a shift-and-add multiply on the word state. Tokens
// pass through the five-stage modulo pipeline into the result queue.
// A text beat that yields two tokens holds the token channel for two beats.
// Every accepted byte reserves one slot of an eight-entry result queue until
// its tokens have gone, so text_ready falls only once eight bytes are
// outstanding while the receiver stalls; nothing is ever dropped.
// Reset returns the word state, the counters and both registers to their
// defaults (interval 64, end token 0); the cfg port writes a register and
// is to be used only while the block is idle, which the block does not enforce.
module word_hash_tokenizer #(
	parameter int MAX_WORD_LEN = 255
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              text_valid,
	output logic                                   text_ready,
	input  wire whtok_pkg::tok_in_t                text_beat,
	output logic                                   token_valid,
	input  wire logic                              token_ready,
	output whtok_pkg::tok_out_t                    token_beat,
	input  wire logic                              cfg_we,
	input  wire logic [whtok_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                       cfg_wdata
);

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

	// Configuration registers.
	logic [15:0] eos_interval_q;
	logic [31:0] eos_token_q;

	// Word state.
	logic [63:0]      hash_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      words_q;

	// Input side decisions.
	logic        accept;
	logic [7:0]  c;
	logic        is_word;
	logic        join_w;
	logic        flush_a;
	logic        flush_b;
	logic        eos_hit;
	logic [63:0] hash_x;
	logic [63:0] hash_join;
	logic [15:0] words_a;

	always_comb begin
		c       = text_beat.text_byte;
		accept  = text_valid && text_ready;
		is_word = (c >= 8'h61 && c <= 8'h7A) ||	// a to z
		          (c >= 8'h41 && c <= 8'h5A) ||	// A to Z
		          (c >= 8'h30 && c <= 8'h39) ||	// 0 to 9
		          (c == 8'h5F);			// underscore
		join_w  = is_word && (len_q < LEN_W'(MAX_WORD_LEN));
		// Any byte that does not join closes a pending word first.
		flush_a = !join_w && (len_q != '0);
		words_a = (flush_a && words_q != 16'hFFFF) ? words_q + 16'd1 : words_q;
		eos_hit = !join_w && (c == whtok_pkg::CH_LF || c == whtok_pkg::CH_DOT) &&
		          (words_a >= eos_interval_q);
		// The byte that joins and also ends the text flushes the grown word.
		flush_b = join_w && text_beat.end_of_text;
		hash_x  = hash_q ^ {56'd0, c};
		// Multiply by 2^40 + 0x1B3, modulo 2^64.
		hash_join = (hash_x << 40) + (hash_x << 8) + (hash_x << 7) + (hash_x << 5) +
		            (hash_x << 4) + (hash_x << 1) + hash_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eos_interval_q <= whtok_pkg::EOS_INTERVAL_RST;
			eos_token_q    <= whtok_pkg::EOS_TOKEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				whtok_pkg::REG_EOS_INTERVAL: eos_interval_q <= cfg_wdata[15:0];
				whtok_pkg::REG_EOS_TOKEN:    eos_token_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= whtok_pkg::FNV_BASIS;
			len_q   <= '0;
			words_q <= '0;
		end else if (accept) begin
			if (join_w && !text_beat.end_of_text) begin
				hash_q <= hash_join;
				len_q  <= len_q + LEN_W'(1);
			end else begin
				hash_q <= whtok_pkg::FNV_BASIS;
				len_q  <= '0;
			end
			if (text_beat.end_of_text) begin
				words_q <= '0;
			end else if (eos_hit) begin
				words_q <= '0;
			end else begin
				words_q <= words_a;
			end
		end
	end

	// Modulo pipeline: reduce the 64-bit hash by residues of powers of two,
	// estimate the quotient with a reciprocal, subtract and correct once.
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        wd_s1, wd_s2, wd_s3, wd_s4, wd_s5;
	logic        eo_s1, eo_s2, eo_s3, eo_s4, eo_s5;
	logic [63:0] hash_s1;
	logic [35:0] fold_s2;
	logic [30:0] val_s3;
	logic [30:0] val_s4;
	logic [whtok_pkg::QUOT_W-1:0] quot_s4;
	logic [whtok_pkg::VOC_W:0]    rem_s5;

	logic [35:0] fold_d;
	logic [30:0] val_d;
	logic [62:0] recip_prod;
	logic [31:0] qm_prod;
	logic [whtok_pkg::VOC_W:0] rem_fix;
	logic [31:0] word_id;

	always_comb begin
		fold_d = 36'(hash_s1[15:0]) + 36'({hash_s1[31:16], 16'd0}) +
		         36'(34'(hash_s1[47:32]) * 34'(whtok_pkg::RES32)) +
		         36'(34'(hash_s1[63:48]) * 34'(whtok_pkg::RES48));
		val_d  = 31'(fold_s2[23:0]) + 31'(30'(fold_s2[35:24]) * 30'(whtok_pkg::RES24));
		recip_prod = 63'(val_s3) * 63'(whtok_pkg::RECIP_K);
		qm_prod    = 32'(quot_s4) * whtok_pkg::VOCAB_SIZE;
		rem_fix    = (rem_s5 >= (whtok_pkg::VOC_W+1)'(whtok_pkg::VOCAB_SIZE)) ?
		             rem_s5 - (whtok_pkg::VOC_W+1)'(whtok_pkg::VOCAB_SIZE) : rem_s5;
		word_id    = 32'(rem_fix) + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		wd_s1   <= flush_a || flush_b;
		eo_s1   <= eos_hit;
		hash_s1 <= flush_b ? hash_join : hash_q;
		wd_s2   <= wd_s1;
		eo_s2   <= eo_s1;
		fold_s2 <= fold_d;
		wd_s3   <= wd_s2;
		eo_s3   <= eo_s2;
		val_s3  <= val_d;
		wd_s4   <= wd_s3;
		eo_s4   <= eo_s3;
		val_s4  <= val_s3;
		quot_s4 <= whtok_pkg::QUOT_W'(recip_prod >> whtok_pkg::RECIP_SHIFT);
		wd_s5   <= wd_s4;
		eo_s5   <= eo_s4;
		rem_s5  <= (whtok_pkg::VOC_W+1)'(32'(val_s4) - qm_prod);
	end

	// Result queue, one entry per byte that produced tokens.
	whtok_pkg::tok_job_t mem_q [whtok_pkg::FIFO_DEPTH];
	whtok_pkg::tok_job_t head;
	logic [whtok_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [whtok_pkg::CNT_W-1:0] fill_q;
	logic [whtok_pkg::CNT_W-1:0] used_q;
	logic phase_q;
	logic push, drop, pop, out_fire;

	always_comb begin
		push        = v_s5 && (wd_s5 || eo_s5);
		drop        = v_s5 && !(wd_s5 || eo_s5);
		head        = mem_q[rd_ptr_q];
		token_valid = (fill_q != '0);
		text_ready  = (used_q != whtok_pkg::CNT_W'(whtok_pkg::FIFO_DEPTH));
		if (head.word_v && !phase_q) begin
			token_beat.token_id    = head.word_id;
			token_beat.is_eos      = 1'b0;
			token_beat.last_of_run = !head.eos_v;
		end else begin
			token_beat.token_id    = eos_token_q;
			token_beat.is_eos      = 1'b1;
			token_beat.last_of_run = 1'b1;
		end
		out_fire = token_valid && token_ready;
		pop      = out_fire && token_beat.last_of_run;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{word_v: wd_s5, eos_v: eo_s5, word_id: word_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			used_q   <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + whtok_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + whtok_pkg::PTR_W'(1);
			end
			fill_q <= fill_q + whtok_pkg::CNT_W'(push) - whtok_pkg::CNT_W'(pop);
			used_q <= used_q + whtok_pkg::CNT_W'(accept) - whtok_pkg::CNT_W'(pop) -
			          whtok_pkg::CNT_W'(drop);
			if (pop) begin
				phase_q <= 1'b0;
			end else if (out_fire) begin
				phase_q <= 1'b1;
			end
		end
	end

	// The reservation count covers every queued entry and never overruns the queue.
	a_fill_covered: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= used_q && used_q <= whtok_pkg::CNT_W'(whtok_pkg::FIFO_DEPTH))
		else $error("result queue reservation out of step");

	// The second half of a two-token entry is only pending on such an entry.
	a_phase_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (token_valid && head.word_v && head.eos_v))
		else $error("token phase set without a pending end token");

	// A word token always lies in 1 to the vocabulary size.
	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !token_beat.is_eos) |->
		(token_beat.token_id != 32'd0 && token_beat.token_id <= whtok_pkg::VOCAB_SIZE))
		else $error("word token out of range");

	// Only a word token can be followed by another token of the same byte.
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_beat.is_eos) |-> token_beat.last_of_run)
		else $error("end token not last of its run");

	// A word that has just been flushed leaves the length cleared.
	a_len_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (flush_a || flush_b)) |=> (len_q == '0))
		else $error("word length not cleared after flush");

endmodule

`default_nettype wire
